/* rtl/pkpls_pkg.sv */
// Shared types, constants and helpers for the power key press detector.
package pkpls_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS = 40;
    localparam int OUT_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP       = 3'd4;

    localparam logic REQ_BOOT = 1'b0;

    localparam logic [15:0] RST_DEBOUNCE    = 16'd30;
    localparam logic [15:0] RST_HOLD        = 16'd2000;
    localparam logic [15:0] RST_SHORT_LIMIT = 16'd500;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic        active_low;
        logic [15:0] debounce_time;
        logic [15:0] hold_time;
        logic [15:0] short_press_limit;
        logic        sleep_on_shutdown;
    } t_cfg;

    typedef struct packed {
        logic  req_type;
        logic  key_level;
        logic [31:0] now_ms;
    } t_item;

    // packed with latch_out in the lowest bit
    typedef struct packed {
        logic on_battery;
        logic sleep_request;
        logic shutdown;
        logic short_press;
        logic key_pressed;
        logic latch_out;
    } t_result;

    function automatic t_time to_time32(input logic [31:0] v);
        logic [63:0] w;
        w = {32'd0, v};
        return w[TIME_BITS-1:0];
    endfunction

    function automatic t_time to_time16(input logic [15:0] v);
        logic [63:0] w;
        w = {48'd0, v};
        return w[TIME_BITS-1:0];
    endfunction

endpackage

/* rtl/power_key_long_short_press_core.sv */
// Top level of the power key press detector: input stage, update and result register.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser: req_type; tdata: key_level, now_ms
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata: latch_out .. on_battery
//  cfg     | in  | i_cfg_we                     | i_cfg_idx, i_cfg_wdata
//
// One sample a cycle while m_axis is not stalled; an accepted sample passes the input
// register, then the state update into the result register, before its result beat
// goes valid on m_axis.
// Synchronous active-low reset clears the state and loads register defaults.
// A stall on m_axis holds the result and the pending sample; s_axis keeps
// taking beats as long as the input stage can move on.
module power_key_long_short_press_core
    import pkpls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [0] key_level, [32:1] now_ms
    input  logic                     s_axis_tuser,   // [0] req_type
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // latch_out, key_pressed,
                                                     // short_press, shutdown,
                                                     // sleep_request, on_battery
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    // move the held sample into the result register when it is empty or its beat is taken
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    pkpls_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pkpls_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.req_type  <= s_axis_tuser;
            r_in_item.key_level <= s_axis_tdata[0];
            r_in_item.now_ms    <= s_axis_tdata[32:1];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule

/* rtl/pkpls_cfg.sv */
// Configuration register file of the power key press detector.
module pkpls_cfg
    import pkpls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_LOW:  n_cfg.active_low        = i_cfg_wdata[0];
                CFG_DEBOUNCE:    n_cfg.debounce_time     = i_cfg_wdata;
                CFG_HOLD:        n_cfg.hold_time         = i_cfg_wdata;
                CFG_SHORT_LIMIT: n_cfg.short_press_limit = i_cfg_wdata;
                CFG_SLEEP:       n_cfg.sleep_on_shutdown = i_cfg_wdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low        <= 1'b1;
            r_cfg.debounce_time     <= RST_DEBOUNCE;
            r_cfg.hold_time         <= RST_HOLD;
            r_cfg.short_press_limit <= RST_SHORT_LIMIT;
            r_cfg.sleep_on_shutdown <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/pkpls_step.sv */
// Debounce, press timing and shutdown state with the per-sample update.
module pkpls_step
    import pkpls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic  r_last_raw,  n_last_raw;
    t_time r_edge_time, n_edge_time;
    logic  r_stable,    n_stable;
    t_time r_press_time, n_press_time;
    logic  r_press_valid, n_press_valid;
    logic  r_armed,     n_armed;
    logic  r_battery,   n_battery;
    logic  r_shutdown,  n_shutdown;
    logic  r_latch,     n_latch;
    logic  r_sleep,     n_sleep;

    logic  raw;
    logic  pulse;
    t_time now;

    always_comb begin
        now = to_time32(i_item.now_ms);
        raw = i_cfg.active_low ? ~i_item.key_level : i_item.key_level;

        n_last_raw    = r_last_raw;
        n_edge_time   = r_edge_time;
        n_stable      = r_stable;
        n_press_time  = r_press_time;
        n_press_valid = r_press_valid;
        n_armed       = r_armed;
        n_battery     = r_battery;
        n_shutdown    = r_shutdown;
        n_latch       = r_latch;
        n_sleep       = r_sleep;
        pulse         = 1'b0;

        if (i_item.req_type == REQ_BOOT) begin
            n_battery     = raw;
            n_latch       = raw;
            n_last_raw    = raw;
            n_edge_time   = now;
            n_stable      = raw;
            n_press_time  = '0;
            n_press_valid = 1'b0;
            n_armed       = 1'b0;
            n_shutdown    = 1'b0;
            n_sleep       = 1'b0;
        end else if (!r_shutdown) begin
            // restart the stable window on every raw change
            if (raw != r_last_raw) begin
                n_last_raw  = raw;
                n_edge_time = now;
            end
            if (t_time'(now - n_edge_time) >= to_time16(i_cfg.debounce_time)) begin
                n_stable = raw;
            end
            if (n_stable) begin
                if (r_armed && !r_press_valid) begin
                    n_press_time  = now;
                    n_press_valid = 1'b1;
                end
                if (r_battery && n_press_valid &&
                    t_time'(now - n_press_time) >= to_time16(i_cfg.hold_time)) begin
                    n_shutdown = 1'b1;
                    n_latch    = 1'b0;
                    n_sleep    = i_cfg.sleep_on_shutdown;
                end
            end else begin
                if (r_press_valid) begin
                    pulse = t_time'(now - r_press_time) <=
                            to_time16(i_cfg.short_press_limit);
                    n_press_valid = 1'b0;
                end
                n_armed = 1'b1;
            end
        end

        o_result.latch_out     = n_latch;
        o_result.key_pressed   = n_stable;
        o_result.short_press   = pulse;
        o_result.shutdown      = n_shutdown;
        o_result.sleep_request = n_sleep;
        o_result.on_battery    = n_battery;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_edge_time   <= '0;
            r_stable      <= 1'b0;
            r_press_time  <= '0;
            r_press_valid <= 1'b0;
            r_armed       <= 1'b0;
            r_battery     <= 1'b0;
            r_shutdown    <= 1'b0;
            r_latch       <= 1'b0;
            r_sleep       <= 1'b0;
        end else if (i_fire) begin
            r_last_raw    <= n_last_raw;
            r_edge_time   <= n_edge_time;
            r_stable      <= n_stable;
            r_press_time  <= n_press_time;
            r_press_valid <= n_press_valid;
            r_armed       <= n_armed;
            r_battery     <= n_battery;
            r_shutdown    <= n_shutdown;
            r_latch       <= n_latch;
            r_sleep       <= n_sleep;
        end
    end

`ifndef ASSERT_OFF
    a_shutdown_drops_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shutdown |-> !r_latch)
        else $error("latch still high after shutdown");
    a_sleep_needs_shutdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep |-> r_shutdown)
        else $error("sleep request without shutdown");
    a_press_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press_valid |-> r_armed)
        else $error("press timed before a release was seen");
    a_latch_battery_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latch |-> r_battery)
        else $error("latch driven high outside battery mode");
`endif

endmodule

/* sim/power_key_long_short_press_core_checker.sv */
// Checker for the power key press detector: predicts each result beat and compares it.
`timescale 1ns / 1ps
module power_key_long_short_press_core_checker
    import pkpls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [0] key_level, [32:1] now_ms
    input  logic                     s_axis_tuser,   // [0] req_type
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // latch_out, key_pressed, short_press,
                                                     // shutdown, sleep_request, on_battery
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending
);

    t_cfg    key_cfg;
    logic    last_raw, stable_state, press_valid, armed;
    logic    battery_flag, shutdown_flag, latch_level, sleep_flag;
    t_time   edge_time, press_time;
    t_result key_results[$];
    t_result want_res, got_res, next_res;
    int      mismatches;

    task automatic advance_press_state(input logic req, input logic level, input t_time now,
                                       output t_result res);
        logic  raw;
        logic  pulse;
        t_time since;
        raw   = key_cfg.active_low ? ~level : level;
        pulse = 1'b0;
        if (req == REQ_BOOT) begin
            battery_flag  = raw;
            latch_level   = raw;
            last_raw      = raw;
            edge_time     = now;
            stable_state  = raw;
            press_time    = '0;
            press_valid   = 1'b0;
            armed         = 1'b0;
            shutdown_flag = 1'b0;
            sleep_flag    = 1'b0;
        end else if (!shutdown_flag) begin
            if (raw != last_raw) begin
                last_raw  = raw;
                edge_time = now;
            end
            since = now - edge_time;
            if (since >= t_time'(key_cfg.debounce_time))
                stable_state = raw;
            if (stable_state) begin
                if (armed && !press_valid) begin
                    press_time  = now;
                    press_valid = 1'b1;
                end
                since = now - press_time;
                if (battery_flag && press_valid && since >= t_time'(key_cfg.hold_time)) begin
                    shutdown_flag = 1'b1;
                    latch_level   = 1'b0;
                    sleep_flag    = key_cfg.sleep_on_shutdown;
                end
            end else begin
                // a release closes the press; only a press that started after arming counts
                if (press_valid) begin
                    since = now - press_time;
                    if (since <= t_time'(key_cfg.short_press_limit))
                        pulse = 1'b1;
                    press_valid = 1'b0;
                end
                armed = 1'b1;
            end
        end
        res.latch_out     = latch_level;
        res.key_pressed   = stable_state;
        res.short_press   = pulse;
        res.shutdown      = shutdown_flag;
        res.sleep_request = sleep_flag;
        res.on_battery    = battery_flag;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_cfg.active_low        = 1'b1;
            key_cfg.debounce_time     = RST_DEBOUNCE;
            key_cfg.hold_time         = RST_HOLD;
            key_cfg.short_press_limit = RST_SHORT_LIMIT;
            key_cfg.sleep_on_shutdown = 1'b0;
            last_raw      = 1'b0;
            edge_time     = '0;
            stable_state  = 1'b0;
            press_time    = '0;
            press_valid   = 1'b0;
            armed         = 1'b0;
            battery_flag  = 1'b0;
            shutdown_flag = 1'b0;
            latch_level   = 1'b0;
            sleep_flag    = 1'b0;
            key_results.delete();
            mismatches    = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE_LOW:  key_cfg.active_low        = i_cfg_wdata[0];
                    CFG_DEBOUNCE:    key_cfg.debounce_time     = i_cfg_wdata;
                    CFG_HOLD:        key_cfg.hold_time         = i_cfg_wdata;
                    CFG_SHORT_LIMIT: key_cfg.short_press_limit = i_cfg_wdata;
                    CFG_SLEEP:       key_cfg.sleep_on_shutdown = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = t_result'(m_axis_tdata[5:0]);
                if (key_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat %h with no sample pending", $realtime,
                                 m_axis_tdata);
                end else begin
                    want_res = key_results.pop_front();
                    if (got_res !== want_res || m_axis_tdata[7:6] !== 2'b00) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch (exp/got) latch %b/%b pressed %b/%b ",
                                      "short %b/%b shutdown %b/%b sleep %b/%b battery %b/%b ",
                                      "pad 00/%b"}, $realtime,
                                     want_res.latch_out, got_res.latch_out,
                                     want_res.key_pressed, got_res.key_pressed,
                                     want_res.short_press, got_res.short_press,
                                     want_res.shutdown, got_res.shutdown,
                                     want_res.sleep_request, got_res.sleep_request,
                                     want_res.on_battery, got_res.on_battery,
                                     m_axis_tdata[7:6]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_press_state(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[32:1],
                                    next_res);
                key_results.push_back(next_res);
            end
            o_fail_count <= mismatches;
            o_pending    <= key_results.size();
        end
    end

endmodule

/* sim/power_key_long_short_press_core_test.sv */
// Testbench top for the power key press detector: reset, register phases and key stimulus.
`timescale 1ns / 1ps
module power_key_long_short_press_core_test;
    import pkpls_pkg::*;

    localparam logic REQ_POLL = 1'b1;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // [0] key_level, [32:1] now_ms
    logic                     s_axis_tuser = 1'b0; // [0] req_type
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // latch_out, key_pressed, short_press,
                                                   // shutdown, sleep_request, on_battery
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_sent = 0;
    t_time       clock_ms = '0;
    logic        cur_active_low = 1'b1;
    logic [15:0] cur_debounce = RST_DEBOUNCE;
    logic [15:0] cur_hold = RST_HOLD;
    logic [15:0] cur_short = RST_SHORT_LIMIT;

    always #5 i_clk = ~i_clk;

    power_key_long_short_press_core dut (.*);

    power_key_long_short_press_core_checker u_press_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic key_level_for(input logic pressed);
        return pressed ^ cur_active_low;
    endfunction

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_sample(input logic req, input logic level, input t_time now);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, now, level};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic al, input logic [15:0] deb, input logic [15:0] hold,
                                 input logic [15:0] short_lim, input logic sl);
        logic [CFG_IDX_BITS-1:0]  idxs [5];
        logic [CFG_DATA_BITS-1:0] vals [5];
        idxs = '{CFG_ACTIVE_LOW, CFG_DEBOUNCE, CFG_HOLD, CFG_SHORT_LIMIT, CFG_SLEEP};
        vals = '{16'(al), deb, hold, short_lim, 16'(sl)};
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_active_low = al;
        cur_debounce   = deb;
        cur_hold       = hold;
        cur_short      = short_lim;
    endtask

    // Aim durations near the debounce, short and hold thresholds.
    function automatic int unsigned pick_span();
        int unsigned anchor;
        int unsigned jitter;
        int unsigned low;
        case ($urandom_range(3))
            0:       anchor = cur_debounce;
            1:       anchor = cur_short;
            2:       anchor = cur_hold;
            default: anchor = $urandom_range(int'(cur_hold) + int'(cur_debounce) + 8);
        endcase
        jitter = anchor / 8 + 2;
        low    = (anchor > jitter) ? anchor - jitter : 0;
        return $urandom_range(anchor + jitter, low);
    endfunction

    // Hold the key at one level for about span_ms of polls, with an occasional bounce.
    task automatic hold_key(input logic pressed, input int unsigned span_ms);
        int unsigned covered;
        int unsigned adv;
        int unsigned adv_max;
        logic        lvl;
        lvl = key_level_for(pressed);
        if ($urandom_range(3) == 0) begin
            // two polls exactly span_ms apart
            send_sample(REQ_POLL, lvl, clock_ms);
            clock_ms += span_ms;
            send_sample(REQ_POLL, lvl, clock_ms);
        end else begin
            covered = 0;
            adv_max = span_ms / 4 + 1;
            while (covered <= span_ms) begin
                if ($urandom_range(15) == 0)
                    send_sample(REQ_POLL, ~lvl, clock_ms);
                else
                    send_sample(REQ_POLL, lvl, clock_ms);
                adv = $urandom_range(adv_max, 1);
                clock_ms += adv;
                covered  += adv;
            end
        end
    endtask

    task automatic run_phase(input int quota);
        int   stop_at;
        logic pressed;
        stop_at  = items_sent + quota;
        clock_ms = $urandom;
        pressed  = ($urandom_range(9) < 7);
        send_sample(REQ_BOOT, key_level_for(pressed), clock_ms);
        while (items_sent < stop_at) begin
            case ($urandom_range(15))
                0: send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
                1, 2: begin
                    // boot mostly with the key held so battery mode gets exercised
                    pressed = ($urandom_range(9) < 7);
                    send_sample(REQ_BOOT, key_level_for(pressed), clock_ms);
                    clock_ms += $urandom_range(40);
                end
                3: clock_ms += $urandom;
                default: begin
                    pressed = ~pressed;
                    hold_key(pressed, pick_span());
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // poll ahead of any boot, then a short press starting at time zero across the wrap
        send_sample(REQ_POLL, 1'b0, 32'd5);
        send_sample(REQ_BOOT, 1'b1, 32'hFFFF_FFC0);
        send_sample(REQ_POLL, 1'b1, 32'hFFFF_FFD0);
        send_sample(REQ_POLL, 1'b0, 32'hFFFF_FFE0);
        send_sample(REQ_POLL, 1'b0, 32'd0);
        send_sample(REQ_POLL, 1'b1, 32'd10);
        send_sample(REQ_POLL, 1'b1, 32'd40);
        // long press on external power never shuts down
        send_sample(REQ_POLL, 1'b0, 32'd100);
        send_sample(REQ_POLL, 1'b0, 32'd130);
        send_sample(REQ_POLL, 1'b0, 32'd5000);
        send_sample(REQ_POLL, 1'b1, 32'd5010);
        send_sample(REQ_POLL, 1'b1, 32'd5040);
        // battery boot, release to arm, hold to shutdown, then frozen
        send_sample(REQ_BOOT, 1'b0, 32'd6000);
        send_sample(REQ_POLL, 1'b0, 32'd6100);
        send_sample(REQ_POLL, 1'b1, 32'd6200);
        send_sample(REQ_POLL, 1'b1, 32'd6230);
        send_sample(REQ_POLL, 1'b0, 32'd6300);
        send_sample(REQ_POLL, 1'b0, 32'd6330);
        send_sample(REQ_POLL, 1'b0, 32'd8330);
        send_sample(REQ_POLL, 1'b1, 32'd8400);
        // re-boot after shutdown, then a bounce shorter than the debounce time
        send_sample(REQ_BOOT, 1'b1, 32'hFFFF_FFFF);
        send_sample(REQ_POLL, 1'b0, 32'd20);
        send_sample(REQ_POLL, 1'b1, 32'd25);
        send_sample(REQ_POLL, 1'b1, 32'd60);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_settings(1'b1, 16'd5, 16'd120, 16'd40, 1'b1);
                1: load_settings(1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
                2: load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: load_settings(1'b0, 16'($urandom_range(50)), 16'($urandom_range(400)),
                                 16'($urandom_range(200)), 1'($urandom_range(1)));
                4: load_settings(1'b1, RST_DEBOUNCE, RST_HOLD, RST_SHORT_LIMIT, 1'b0);
                5: load_settings(1'b1, 16'd0, 16'hFFFF, 16'd0, 1'b1);
                6: load_settings(1'($urandom_range(1)), 16'($urandom_range(100)),
                                 16'($urandom_range(1000)), 16'($urandom_range(600)),
                                 1'($urandom_range(1)));
                default: load_settings(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            run_phase(190);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("power_key_long_short_press_core_test: PASS");
        else
            $display("power_key_long_short_press_core_test: FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("power_key_long_short_press_core_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/pkpls_pkg.sv
rtl/pkpls_cfg.sv
rtl/pkpls_step.sv
rtl/power_key_long_short_press_core.sv
sim/power_key_long_short_press_core_checker.sv
sim/power_key_long_short_press_core_test.sv
